/* rtl/sensor_bank_recent_history_top_defines.svh */
// Assertion macros used by the checker file of the sensor history block.
// No dependencies; include once per file that asserts.
`ifndef SENSOR_BANK_RECENT_HISTORY_TOP_DEFINES_SVH
`define SENSOR_BANK_RECENT_HISTORY_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SBRH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sensor history check failed");

// Next-cycle implication, disabled during reset.
`define SBRH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sensor history check failed");

`endif

/* rtl/sbrh_pkg.sv */
// Shared types and constants of the sensor bank recent-history block.
// No dependencies; compile first after the macro header.
package sbrh_pkg;

    localparam int KIND_W    = 1;
    localparam int INDEX_W   = 4;
    localparam int BITS_W    = 8;
    localparam int SLOT_W    = 6;
    localparam int MODULE_W  = 3;
    localparam int CONTACT_W = 5;
    localparam int POS_W     = 3;

    localparam int HISTORY_DEPTH_DEF = 8;

    localparam logic [INDEX_W-1:0] DUMP_BYTES  = 4'd10;
    localparam logic [KIND_W-1:0]  KIND_DUMP   = 1'b0;
    localparam logic [KIND_W-1:0]  KIND_READ   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the incoming item
        logic step;      // emit the next set bit; push it unless a duplicate
        logic read_out;  // emit the latched history slot
    } sbrh_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;     // incoming item is a slot readout
        logic has_events;  // incoming item is an in-range dump byte with a set bit
        logic scan_last;   // current step takes the final set bit
        logic out_free;    // output register can take a word this cycle
    } sbrh_status_t;

endpackage

/* rtl/sbrh_if.sv */
// Valid/ready channel interfaces for the item and result words.
// Depends on sbrh_pkg for field widths.
interface sbrh_item_if;
    logic                         valid;
    logic                         ready;
    logic [sbrh_pkg::KIND_W-1:0]  kind;
    logic [sbrh_pkg::INDEX_W-1:0] byte_index;
    logic [sbrh_pkg::BITS_W-1:0]  sensor_bits;
    logic [sbrh_pkg::SLOT_W-1:0]  read_slot;

    modport source (output valid, kind, byte_index, sensor_bits, read_slot, input ready);
    modport sink   (input valid, kind, byte_index, sensor_bits, read_slot, output ready);
endinterface

interface sbrh_result_if;
    logic                           valid;
    logic                           ready;
    logic [sbrh_pkg::MODULE_W-1:0]  module_res;
    logic [sbrh_pkg::CONTACT_W-1:0] contact;
    logic                           recorded;
    logic                           last;

    modport source (output valid, module_res, contact, recorded, last, input ready);
    modport sink   (input valid, module_res, contact, recorded, last, output ready);
endinterface

/* rtl/sbrh_datapath.sv */
// Datapath: item capture, set-bit scan, history shift register, output register.
// Depends on sbrh_pkg.
module sbrh_datapath #(
    parameter int HISTORY_DEPTH = sbrh_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [sbrh_pkg::KIND_W-1:0]    in_kind,
    input  logic [sbrh_pkg::INDEX_W-1:0]   in_byte_index,
    input  logic [sbrh_pkg::BITS_W-1:0]    in_sensor_bits,
    input  logic [sbrh_pkg::SLOT_W-1:0]    in_read_slot,
    input  sbrh_pkg::sbrh_cmd_t            cmd,
    output sbrh_pkg::sbrh_status_t         status,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [sbrh_pkg::MODULE_W-1:0]  out_module_res,
    output logic [sbrh_pkg::CONTACT_W-1:0] out_contact,
    output logic                           out_recorded,
    output logic                           out_last
);

    localparam int IDX_W = $clog2(HISTORY_DEPTH);

    logic [sbrh_pkg::BITS_W-1:0]    mask_reg, mask_next;
    logic [sbrh_pkg::MODULE_W-1:0]  mod_reg;
    logic                           half_reg;
    logic [sbrh_pkg::SLOT_W-1:0]    slot_reg;

    logic [sbrh_pkg::MODULE_W-1:0]  hist_mod_reg [HISTORY_DEPTH];
    logic [sbrh_pkg::CONTACT_W-1:0] hist_con_reg [HISTORY_DEPTH];

    logic                           out_valid_reg, out_valid_next;
    logic [sbrh_pkg::MODULE_W-1:0]  out_mod_reg;
    logic [sbrh_pkg::CONTACT_W-1:0] out_con_reg;
    logic                           out_rec_reg;
    logic                           out_last_reg;

    logic [sbrh_pkg::POS_W-1:0]     pos;
    logic                           found;
    logic [sbrh_pkg::CONTACT_W-1:0] contact_w;
    logic                           dup;
    logic                           slot_in_range;
    logic [sbrh_pkg::MODULE_W-1:0]  rd_mod;
    logic [sbrh_pkg::CONTACT_W-1:0] rd_con;

    // First set bit from the MSB side; position 0 is the MSB.
    always_comb
    begin
        pos   = '0;
        found = 1'b0;
        for (int i = 0; i < sbrh_pkg::BITS_W; i++)
        begin
            if (!found && mask_reg[sbrh_pkg::BITS_W-1-i])
            begin
                pos   = sbrh_pkg::POS_W'(i);
                found = 1'b1;
            end
        end
    end

    assign mask_next = mask_reg & ~(8'h80 >> pos);
    assign contact_w = {1'b0, half_reg, pos} + 5'd1;
    assign dup       = (hist_mod_reg[0] == mod_reg) && (hist_con_reg[0] == contact_w);

    assign slot_in_range = ({1'b0, slot_reg} < 7'(HISTORY_DEPTH));
    assign rd_mod = slot_in_range ? hist_mod_reg[slot_reg[IDX_W-1:0]] : '0;
    assign rd_con = slot_in_range ? hist_con_reg[slot_reg[IDX_W-1:0]] : '0;

    assign status.is_read    = (in_kind == sbrh_pkg::KIND_READ);
    assign status.has_events = (in_kind == sbrh_pkg::KIND_DUMP)
                             && (in_byte_index < sbrh_pkg::DUMP_BYTES)
                             && (|in_sensor_bits);
    assign status.scan_last  = (mask_next == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mask_reg <= in_sensor_bits;
            mod_reg  <= in_byte_index[sbrh_pkg::INDEX_W-1:1];
            half_reg <= in_byte_index[0];
            slot_reg <= in_read_slot;
        end
        else if (cmd.step)
        begin
            mask_reg <= mask_next;
        end
    end

    // History: newest in slot 0, shift on every recorded event.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < HISTORY_DEPTH; s++)
            begin
                hist_mod_reg[s] <= '0;
                hist_con_reg[s] <= '0;
            end
        end
        else if (cmd.step && !dup)
        begin
            for (int s = HISTORY_DEPTH - 1; s > 0; s--)
            begin
                hist_mod_reg[s] <= hist_mod_reg[s-1];
                hist_con_reg[s] <= hist_con_reg[s-1];
            end
            hist_mod_reg[0] <= mod_reg;
            hist_con_reg[0] <= contact_w;
        end
    end

    always_comb
    begin
        if (cmd.step || cmd.read_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            out_mod_reg  <= mod_reg;
            out_con_reg  <= contact_w;
            out_rec_reg  <= !dup;
            out_last_reg <= (mask_next == '0);
        end
        else if (cmd.read_out)
        begin
            out_mod_reg  <= rd_mod;
            out_con_reg  <= rd_con;
            out_rec_reg  <= 1'b0;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_module_res = out_mod_reg;
    assign out_contact    = out_con_reg;
    assign out_recorded   = out_rec_reg;
    assign out_last       = out_last_reg;

endmodule

/* rtl/sbrh_controller.sv */
// Controller state machine: accepts items and sequences scan and readout.
// Depends on sbrh_pkg for the command and status structs.
module sbrh_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sbrh_pkg::sbrh_status_t status,
    output sbrh_pkg::sbrh_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic [1:0] state_reg, state_next;

    assign in_ready     = (state_reg == ST_IDLE);
    assign cmd.load     = in_valid && (state_reg == ST_IDLE);
    assign cmd.step     = (state_reg == ST_SCAN) && status.out_free;
    assign cmd.read_out = (state_reg == ST_READ) && status.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.is_read)
                        state_next = ST_READ;
                    else if (status.has_events)
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.out_free && status.scan_last)
                    state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/sensor_bank_recent_history_top.sv */
// Top level of the sensor bank recent-history block.
// Depends on sbrh_pkg, sbrh_if, sbrh_controller and sbrh_datapath.
//
//   channel   role   word contents
//   item      sink   kind, byte_index, sensor_bits, read_slot
//   result    source module_res, contact, recorded, last
//
// A dump byte with n set bits holds the block while it takes the word and
// then emits one result per set bit through the single-entry output
// register. A readout holds it for one result; an ignored byte gives none.
// A stalled result holds the scan until the word is taken.
// Reset clears the history flip-flops at once; no clearing pass.
module sensor_bank_recent_history_top #(
    parameter int HISTORY_DEPTH = sbrh_pkg::HISTORY_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    sbrh_item_if.sink     item,
    sbrh_result_if.source result
);

    sbrh_pkg::sbrh_cmd_t    cmd;
    sbrh_pkg::sbrh_status_t status;

    sbrh_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sbrh_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_kind        (item.kind),
        .in_byte_index  (item.byte_index),
        .in_sensor_bits (item.sensor_bits),
        .in_read_slot   (item.read_slot),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (result.ready),
        .out_valid      (result.valid),
        .out_module_res (result.module_res),
        .out_contact    (result.contact),
        .out_recorded   (result.recorded),
        .out_last       (result.last)
    );

endmodule

/* rtl/sbrh_checker.sv */
// Port-level checks of the sensor bank recent-history block, bound to the top.
// Depends on sbrh_pkg and the assertion macro header.
`include "sensor_bank_recent_history_top_defines.svh"

module sbrh_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_valid,
    input logic                           item_ready,
    input logic [sbrh_pkg::KIND_W-1:0]    item_kind,
    input logic                           result_valid,
    input logic                           result_ready,
    input logic [sbrh_pkg::MODULE_W-1:0]  result_module_res,
    input logic [sbrh_pkg::CONTACT_W-1:0] result_contact,
    input logic                           result_recorded,
    input logic                           result_last
);

    // Hold a stalled result word: valid, contact and last stay.
    `SBRH_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready,
        result_valid && $stable(result_contact) && $stable(result_last))

    // A recorded event always names a real contact and module.
    `SBRH_ASSERT_NOW(a_recorded_real, clk, rst_n, result_valid && result_recorded,
        result_contact != 5'd0 && result_contact <= 5'd16 && result_module_res <= 3'd4)

    // A readout keeps the block busy for the next cycle.
    `SBRH_ASSERT_NEXT(a_read_busy, clk, rst_n,
        item_valid && item_ready && item_kind == sbrh_pkg::KIND_READ, !item_ready)

    // No new word is taken while a scan still owes results.
    `SBRH_ASSERT_NOW(a_scan_busy, clk, rst_n, result_valid && !result_last, !item_ready)

endmodule

bind sensor_bank_recent_history_top sbrh_checker u_sbrh_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .item_kind         (item.kind),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_module_res (result.module_res),
    .result_contact    (result.contact),
    .result_recorded   (result.recorded),
    .result_last       (result.last)
);
